/* hdl/prtm_pkg.sv */
// Package with types and codes shared by the posted receive tag matcher.
package prtm_pkg;

    localparam int SRC_W = 6;
    localparam int TAG_W = 32;
    localparam int HANDLE_W = 8;
    localparam int SEQ_W = 32;
    localparam int LEN_W = 32;
    localparam int STAMP_W = 32;

    typedef enum logic [1:0] {
        MODE_POST    = 2'd0,
        MODE_MATCH   = 2'd1,
        MODE_LOOKUP  = 2'd2,
        MODE_RELEASE = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOMATCH = 2'd1,
        ST_FULL    = 2'd2
    } status_t;

    typedef struct packed {
        mode_t                       mode;
        logic [SRC_W-1:0]            source;
        logic                        any_source;
        logic signed [TAG_W-1:0]     msg_tag;
        logic                        any_tag;
        logic [HANDLE_W-1:0]         recv_handle;
        logic [SEQ_W-1:0]            send_seq;
        logic [LEN_W-1:0]            msg_length;
    } req_t;

    typedef struct packed {
        status_t                     status;
        logic [HANDLE_W-1:0]         match_handle;
        logic [SRC_W-1:0]            match_peer;
        logic signed [TAG_W-1:0]     match_tag;
        logic [LEN_W-1:0]            match_length;
    } rsp_t;

    // Posted receive entry (valid bit kept separately).
    typedef struct packed {
        logic                        any_src;
        logic                        any_tg;
        logic [SRC_W-1:0]            src;
        logic [TAG_W-1:0]            tag;
        logic [HANDLE_W-1:0]         handle;
        logic [STAMP_W-1:0]          stamp;
    } post_ent_t;

    // Matched receive entry (valid bit kept separately).
    typedef struct packed {
        logic [HANDLE_W-1:0]         handle;
        logic [SRC_W-1:0]            peer;
        logic [TAG_W-1:0]            tag;
        logic [SEQ_W-1:0]            seq;
        logic [LEN_W-1:0]            len;
    } match_ent_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_COMMIT,
        S_RESP
    } fsm_t;

endpackage

/* hdl/posted_receive_tag_matcher_top.sv */
// Posted receive tag matcher: posted and matched tables in synchronous memories, scanned per item.
//
// One item is taken at a time. A fragment match scans the posted table, and a lookup or a release
// scans the matched table, one entry per cycle through the memory read port, whose read data is
// registered. Posts, and items with a source out of range, need no scan and pass straight from
// the scan state to the commit step. Free slots come from the valid bits, so a match does not
// scan the matched table. Valid bits of both tables are flip-flops cleared by reset, so no
// clearing pass is needed. The result sits in an output register, and the next item may not
// enter until it is taken.
module posted_receive_tag_matcher_top #(
    parameter int NUM_PROCS     = 64,
    parameter int POSTED_DEPTH  = 64,
    parameter int MATCHED_DEPTH = 64
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  prtm_pkg::req_t   in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output prtm_pkg::rsp_t   out_data
);
    import prtm_pkg::*;

    localparam int PW = (POSTED_DEPTH > 1) ? $clog2(POSTED_DEPTH) : 1;
    localparam int MW = (MATCHED_DEPTH > 1) ? $clog2(MATCHED_DEPTH) : 1;
    localparam int MAXD = (POSTED_DEPTH > MATCHED_DEPTH) ? POSTED_DEPTH : MATCHED_DEPTH;
    localparam int CW = $clog2(MAXD + 2);

    // Storage.
    post_ent_t  post_mem [POSTED_DEPTH];
    match_ent_t match_mem [MATCHED_DEPTH];
    logic [POSTED_DEPTH-1:0]  pvalid_reg;
    logic [MATCHED_DEPTH-1:0] mvalid_reg;
    post_ent_t  prd_reg;
    match_ent_t mrd_reg;

    // Control state.
    fsm_t state_reg, state_next;
    req_t req_reg;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] rd_idx_reg;
    logic          rd_live_reg;
    logic [STAMP_W-1:0] post_counter_reg;
    logic          best_ok_reg, best_ok_next;
    logic [PW-1:0] best_reg, best_next;
    logic [STAMP_W-1:0] best_age_reg, best_age_next;
    logic [HANDLE_W-1:0] best_handle_reg, best_handle_next;
    logic          mhit_reg, mhit_next;
    logic [MW-1:0] mhit_idx_reg, mhit_idx_next;
    match_ent_t    mhit_ent_reg, mhit_ent_next;
    logic          pfree_ok, mfree_ok;
    logic [PW-1:0] pfree_idx;
    logic [MW-1:0] mfree_idx;
    logic          src_bad;
    rsp_t          rsp_reg, rsp_next;
    logic          out_valid_reg;

    logic [STAMP_W-1:0] age;
    logic          tag_hit, post_hit, match_key_hit;
    logic [PW-1:0] rd_pidx;
    logic [MW-1:0] rd_midx;
    logic          scan_p_ok, scan_m_ok;

    assign in_ready  = (state_reg == S_IDLE) && !out_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = rsp_reg;

    // Lowest free slot of each table from the valid bits.
    always_comb
    begin
        pfree_ok  = 1'b0;
        pfree_idx = '0;
        for (int i = POSTED_DEPTH - 1; i >= 0; i--)
        begin
            if (!pvalid_reg[i])
            begin
                pfree_ok  = 1'b1;
                pfree_idx = PW'(i);
            end
        end
        mfree_ok  = 1'b0;
        mfree_idx = '0;
        for (int i = MATCHED_DEPTH - 1; i >= 0; i--)
        begin
            if (!mvalid_reg[i])
            begin
                mfree_ok  = 1'b1;
                mfree_idx = MW'(i);
            end
        end
    end

    // A release ignores the source; a post with any source accepts every source.
    assign src_bad = (32'(req_reg.source) >= 32'(NUM_PROCS)) &&
                     (req_reg.mode != MODE_RELEASE) &&
                     !(req_reg.mode == MODE_POST && req_reg.any_source);

    // Entry evaluation of the word read in the previous cycle.
    assign rd_pidx   = rd_idx_reg[PW-1:0];
    assign rd_midx   = rd_idx_reg[MW-1:0];
    assign scan_p_ok = rd_live_reg && (32'(rd_idx_reg) < 32'(POSTED_DEPTH));
    assign scan_m_ok = rd_live_reg && (32'(rd_idx_reg) < 32'(MATCHED_DEPTH));
    assign age       = post_counter_reg - prd_reg.stamp;
    assign tag_hit   = prd_reg.any_tg ? !req_reg.msg_tag[TAG_W-1]
                                      : (prd_reg.tag == req_reg.msg_tag);
    assign post_hit  = scan_p_ok && pvalid_reg[rd_pidx] &&
                       (prd_reg.any_src || prd_reg.src == req_reg.source) && tag_hit;
    assign match_key_hit = scan_m_ok && mvalid_reg[rd_midx] &&
        ((req_reg.mode == MODE_LOOKUP)
            ? (mrd_reg.peer == req_reg.source && mrd_reg.seq == req_reg.send_seq)
            : (mrd_reg.handle == req_reg.recv_handle));

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (in_valid && in_ready) state_next = S_SCAN;
            S_SCAN:
            begin
                if (src_bad || req_reg.mode == MODE_POST)
                    state_next = S_COMMIT;
                else if (32'(cnt_reg) > 32'(MAXD))
                    state_next = S_COMMIT;
            end
            S_COMMIT: state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // Scan bookkeeping.
    always_comb
    begin
        cnt_next         = cnt_reg + 1'b1;
        best_ok_next     = best_ok_reg;
        best_next        = best_reg;
        best_age_next    = best_age_reg;
        best_handle_next = best_handle_reg;
        mhit_next        = mhit_reg;
        mhit_idx_next    = mhit_idx_reg;
        mhit_ent_next    = mhit_ent_reg;
        if (req_reg.mode == MODE_MATCH && post_hit &&
            (!best_ok_reg || age > best_age_reg))
        begin
            best_ok_next     = 1'b1;
            best_next        = rd_pidx;
            best_age_next    = age;
            best_handle_next = prd_reg.handle;
        end
        if ((req_reg.mode == MODE_LOOKUP || req_reg.mode == MODE_RELEASE) &&
            match_key_hit && !mhit_reg)
        begin
            mhit_next     = 1'b1;
            mhit_idx_next = rd_midx;
            mhit_ent_next = mrd_reg;
        end
    end

    // Result of the item being committed.
    always_comb
    begin
        rsp_next = '0;
        if (src_bad)
            rsp_next.status = ST_NOMATCH;
        else
        begin
            unique case (req_reg.mode)
                MODE_POST:
                begin
                    if (pfree_ok)
                    begin
                        rsp_next.status       = ST_OK;
                        rsp_next.match_handle = req_reg.recv_handle;
                    end
                    else
                        rsp_next.status = ST_FULL;
                end
                MODE_MATCH:
                begin
                    if (!best_ok_reg)
                        rsp_next.status = ST_NOMATCH;
                    else if (!mfree_ok)
                        rsp_next.status = ST_FULL;
                    else
                    begin
                        rsp_next.status       = ST_OK;
                        rsp_next.match_handle = best_handle_reg;
                        rsp_next.match_peer   = req_reg.source;
                        rsp_next.match_tag    = req_reg.msg_tag;
                        rsp_next.match_length = req_reg.msg_length;
                    end
                end
                default:
                begin
                    if (mhit_reg)
                    begin
                        rsp_next.status       = ST_OK;
                        rsp_next.match_handle = mhit_ent_reg.handle;
                        rsp_next.match_peer   = mhit_ent_reg.peer;
                        rsp_next.match_tag    = mhit_ent_reg.tag;
                        rsp_next.match_length = mhit_ent_reg.len;
                    end
                    else
                        rsp_next.status = ST_NOMATCH;
                end
            endcase
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            out_valid_reg    <= 1'b0;
            pvalid_reg       <= '0;
            mvalid_reg       <= '0;
            post_counter_reg <= '0;
            cnt_reg          <= '0;
            rd_live_reg      <= 1'b0;
            best_ok_reg      <= 1'b0;
            mhit_reg         <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            if (state_reg == S_IDLE)
            begin
                cnt_reg     <= '0;
                rd_live_reg <= 1'b0;
                best_ok_reg <= 1'b0;
                mhit_reg    <= 1'b0;
            end
            else if (state_reg == S_SCAN)
            begin
                cnt_reg     <= cnt_next;
                rd_live_reg <= 32'(cnt_reg) < 32'(MAXD);
                best_ok_reg <= best_ok_next;
                mhit_reg    <= mhit_next;
            end
            if (state_reg == S_COMMIT)
            begin
                out_valid_reg <= 1'b1;
                if (!src_bad)
                begin
                    unique case (req_reg.mode)
                        MODE_POST:
                        begin
                            if (pfree_ok)
                            begin
                                pvalid_reg[pfree_idx] <= 1'b1;
                                post_counter_reg      <= post_counter_reg + 1'b1;
                            end
                        end
                        MODE_MATCH:
                        begin
                            if (best_ok_reg && mfree_ok)
                            begin
                                pvalid_reg[best_reg]  <= 1'b0;
                                mvalid_reg[mfree_idx] <= 1'b1;
                            end
                        end
                        MODE_RELEASE:
                            if (mhit_reg) mvalid_reg[mhit_idx_reg] <= 1'b0;
                        MODE_LOOKUP: ;
                        default: ;
                    endcase
                end
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            req_reg <= in_data;
        rd_idx_reg      <= cnt_reg;
        best_reg        <= best_next;
        best_age_reg    <= best_age_next;
        best_handle_reg <= best_handle_next;
        mhit_idx_reg    <= mhit_idx_next;
        mhit_ent_reg    <= mhit_ent_next;
        if (state_reg == S_COMMIT)
            rsp_reg <= rsp_next;
    end

    // Posted table memory: scan read, write on a successful post.
    always_ff @(posedge clk)
    begin
        prd_reg <= post_mem[cnt_reg[PW-1:0]];
        if (state_reg == S_COMMIT && !src_bad && req_reg.mode == MODE_POST && pfree_ok)
            post_mem[pfree_idx] <= '{any_src: req_reg.any_source, any_tg: req_reg.any_tag,
                                     src: req_reg.source, tag: req_reg.msg_tag,
                                     handle: req_reg.recv_handle, stamp: post_counter_reg};
    end

    // Matched table memory: scan read, write on a successful match.
    always_ff @(posedge clk)
    begin
        mrd_reg <= match_mem[cnt_reg[MW-1:0]];
        if (state_reg == S_COMMIT && !src_bad && req_reg.mode == MODE_MATCH &&
            best_ok_reg && mfree_ok)
            match_mem[mfree_idx] <= '{handle: best_handle_reg, peer: req_reg.source,
                                      tag: req_reg.msg_tag, seq: req_reg.send_seq,
                                      len: req_reg.msg_length};
    end

    // A result is only produced after a commit step.
    a_out_after_commit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == S_COMMIT)
        else $error("result raised without a commit");

    // A new item never enters while a result waits.
    a_no_accept_pending: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !in_ready)
        else $error("item accepted while result pending");

    // The post counter only moves on a committed post.
    a_counter_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (post_counter_reg != $past(post_counter_reg)) |->
            $past(state_reg) == S_COMMIT && $past(req_reg.mode) == MODE_POST)
        else $error("post counter changed outside a post");

endmodule
